### rtl/core/wrrs_pkg.sv
// Shared types and constants for the weighted round-robin scheduler.
// No dependencies; imported by wrrs_ctrl, wrrs_dp and the top level.
package wrrs_pkg;
    localparam int MAX_DESTS   = 64;
    localparam int WEIGHT_BITS = 16;
    localparam int IDX_W       = $clog2(MAX_DESTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int CW_W        = WEIGHT_BITS + 2;
    localparam int SHIFT_W     = $clog2(WEIGHT_BITS + 1);
    localparam int SKIP_W      = 8;
    localparam int CFG_DATA_W  = 8;

    // input item kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_COMMIT = 2'd1;
    localparam logic [1:0] KIND_PACKET = 2'd2;

    // configuration register indexes
    localparam logic CFG_DEST_COUNT    = 1'b0;
    localparam logic CFG_SKIP_INTERVAL = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic accept;     // an input transaction is taken
        logic pkt;        // report result, evaluate skip count
        logic walk_init;  // capture walk start point
        logic walk_step;  // advance pointer one place
        logic walk_chk;   // test the read entry
        logic com_init;   // clear commit accumulators
        logic com_use;    // fold one read weight
        logic gcd_step;   // one gcd iteration
        logic com_fin;    // publish commit results
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic need_walk;  // skip count expired
        logic step_ret;   // walk ends without a table check
        logic chk_end;    // walk ends after this check
        logic table_empty;
        logic need_gcd;   // read weight needs a gcd with the running value
        logic gcd_done;
        logic com_last;   // last entry of the commit scan
    } t_sts;
endpackage

### rtl/core/wrrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wrrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/wrrs_ctrl.sv
// Sequencer for packets, pointer walks and commit scans.
// Depends on wrrs_pkg; drives wrrs_dp through t_cmd, reads t_sts.
module wrrs_ctrl import wrrs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_kind,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy
);
    typedef enum logic [2:0] {
        S_IDLE, S_PKT, S_WSTEP, S_WCHK, S_CRD, S_CUSE, S_GCD, S_CFIN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_kind == KIND_PACKET) begin
                        n_state = S_PKT;
                    end else if (i_kind == KIND_COMMIT) begin
                        o_cmd.com_init = 1'b1;
                        n_state = i_sts.table_empty ? S_CFIN : S_CRD;
                    end
                end
            end
            S_PKT: begin
                o_cmd.pkt = 1'b1;
                if (i_sts.need_walk) begin
                    o_cmd.walk_init = 1'b1;
                    n_state = S_WSTEP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WSTEP: begin
                o_cmd.walk_step = 1'b1;
                n_state = i_sts.step_ret ? S_IDLE : S_WCHK;
            end
            S_WCHK: begin
                o_cmd.walk_chk = 1'b1;
                n_state = i_sts.chk_end ? S_IDLE : S_WSTEP;
            end
            S_CRD: begin
                n_state = S_CUSE;
            end
            S_CUSE: begin
                o_cmd.com_use = 1'b1;
                if (i_sts.need_gcd) begin
                    n_state = S_GCD;
                end else begin
                    n_state = i_sts.com_last ? S_CFIN : S_CRD;
                end
            end
            S_GCD: begin
                o_cmd.gcd_step = 1'b1;
                if (i_sts.gcd_done) begin
                    n_state = i_sts.com_last ? S_CFIN : S_CRD;
                end
            end
            S_CFIN: begin
                o_cmd.com_fin = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;
endmodule

### rtl/core/wrrs_dp.sv
// Datapath: entry table, pointer, weights, skip count, gcd unit, result regs.
// Depends on wrrs_pkg and wrrs_ram.
module wrrs_dp import wrrs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [1:0]             i_kind,
    input  logic [IDX_W-1:0]       i_entry_index,
    input  logic [WEIGHT_BITS-1:0] i_entry_weight,
    input  logic                   i_entry_available,
    input  logic                   i_cfg_wr,
    input  logic                   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_valid,
    output logic                   o_dest_found,
    output logic [IDX_W-1:0]       o_dest_index
);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DESTS);

    // configuration
    logic [CNT_W-1:0]  r_dest_count;
    logic [SKIP_W-1:0] r_skip_interval;
    // scheduling state
    logic                    r_at_head, r_start_head;
    logic [IDX_W-1:0]        r_pos, r_start_pos;
    logic signed [CW_W-1:0]  r_cw;
    logic [WEIGHT_BITS-1:0]  r_largest, r_step;
    logic [SKIP_W-1:0]       r_skip;
    // commit scan and gcd
    logic [IDX_W-1:0]        r_idx;
    logic [WEIGHT_BITS-1:0]  r_mx, r_g, r_a, r_b;
    logic [SHIFT_W-1:0]      r_k;
    // result
    logic             r_out_valid, r_out_found;
    logic [IDX_W-1:0] r_out_index;

    logic [CNT_W-1:0]       used_n;
    logic [WEIGHT_BITS:0]   rdata;
    logic [WEIGHT_BITS-1:0] rd_w;
    logic                   rd_av;
    logic [IDX_W-1:0]       raddr;
    logic                   s_head, s_ret;
    logic [IDX_W-1:0]       s_pos;
    logic signed [CW_W-1:0] s_cw;
    logic [CNT_W-1:0]       pos_inc;
    logic                   hit, term;
    logic [WEIGHT_BITS-1:0] gcd_res;

    assign used_n = (r_dest_count > MAX_CNT) ? MAX_CNT : r_dest_count;
    assign rd_w   = rdata[WEIGHT_BITS-1:0];
    assign rd_av  = rdata[WEIGHT_BITS];

    // one walk step from the current pointer
    always_comb begin
        s_head  = r_at_head;
        s_pos   = r_pos;
        s_cw    = r_cw;
        s_ret   = 1'b0;
        pos_inc = {1'b0, r_pos} + CNT_W'(1);
        if (r_at_head) begin
            if (used_n == '0) begin
                s_ret = 1'b1;
            end else begin
                s_head = 1'b0;
                s_pos  = '0;
                s_cw   = r_cw - $signed({2'b00, r_step});
                if (s_cw <= 0) begin
                    s_cw = $signed({2'b00, r_largest});
                    if (r_largest == '0) begin
                        s_head = 1'b1;
                        s_ret  = 1'b1;
                    end
                end
            end
        end else if (pos_inc >= used_n) begin
            s_head = 1'b1;
            s_pos  = '0;
        end else begin
            s_pos = pos_inc[IDX_W-1:0];
        end
    end

    assign raddr = i_cmd.walk_step ? s_pos : r_idx;

    wrrs_ram #(.WIDTH(WEIGHT_BITS + 1), .DEPTH(MAX_DESTS)) u_table (
        .i_clk  (i_clk),
        .i_we   (i_cmd.accept && (i_kind == KIND_WRITE)),
        .i_waddr(i_entry_index),
        .i_wdata({i_entry_available, i_entry_weight}),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // walk check: hit an eligible entry, or back at the starting point
    assign hit  = !r_at_head && rd_av && ($signed({2'b00, rd_w}) >= r_cw);
    assign term = (r_at_head == r_start_head) && (r_at_head || (r_pos == r_start_pos))
                  && (r_cw == $signed({2'b00, r_step}));

    assign gcd_res = (r_a | r_b) << r_k;

    always_comb begin
        o_sts.need_walk   = !(r_skip < r_skip_interval);
        o_sts.step_ret    = s_ret;
        o_sts.chk_end     = hit || term;
        o_sts.table_empty = (used_n == '0);
        o_sts.need_gcd    = (rd_w != '0) && (r_g != '0);
        o_sts.gcd_done    = (r_a == '0) || (r_b == '0);
        o_sts.com_last    = ({1'b0, r_idx} == used_n - CNT_W'(1));
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_count    <= '0;
            r_skip_interval <= '0;
            r_at_head       <= 1'b1;
            r_pos           <= '0;
            r_cw            <= '0;
            r_largest       <= '0;
            r_step          <= WEIGHT_BITS'(1);
            r_skip          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.pkt;
            if (i_cfg_wr) begin
                if (i_cfg_index == CFG_DEST_COUNT) begin
                    r_dest_count <= i_cfg_data[CNT_W-1:0];
                end else begin
                    r_skip_interval <= i_cfg_data[SKIP_W-1:0];
                end
            end
            if (i_cmd.pkt) begin
                r_skip <= o_sts.need_walk ? '0 : r_skip + SKIP_W'(1);
            end
            if (i_cmd.walk_init && !r_at_head && ({1'b0, r_pos} >= used_n)) begin
                r_at_head <= 1'b1;
            end
            if (i_cmd.walk_step) begin
                r_at_head <= s_head;
                r_pos     <= s_pos;
                r_cw      <= s_cw;
            end
            if (i_cmd.walk_chk && !hit && term) begin
                r_at_head <= 1'b1;
                r_pos     <= '0;
            end
            if (i_cmd.com_fin) begin
                r_largest <= r_mx;
                r_step    <= (r_g != '0) ? r_g : WEIGHT_BITS'(1);
                r_skip    <= '0;
                r_at_head <= 1'b1;
                r_pos     <= '0;
                if (r_cw > $signed({2'b00, r_mx})) begin
                    r_cw <= '0;
                end
            end
        end
    end

    // walk start point, commit accumulators, binary gcd, result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_start_head <= r_at_head || ({1'b0, r_pos} >= used_n);
            r_start_pos  <= r_pos;
        end
        if (i_cmd.pkt) begin
            r_out_found <= !r_at_head && ({1'b0, r_pos} < used_n);
            r_out_index <= (!r_at_head && ({1'b0, r_pos} < used_n)) ? r_pos : '0;
        end
        if (i_cmd.com_init) begin
            r_idx <= '0;
            r_mx  <= '0;
            r_g   <= '0;
        end
        if (i_cmd.com_use) begin
            if (rd_w > r_mx) begin
                r_mx <= rd_w;
            end
            if (rd_w != '0 && r_g == '0) begin
                r_g <= rd_w;
            end
            r_a <= rd_w;
            r_b <= r_g;
            r_k <= '0;
            if (!o_sts.need_gcd) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
        if (i_cmd.gcd_step) begin
            if (o_sts.gcd_done) begin
                r_g   <= gcd_res;
                r_idx <= r_idx + IDX_W'(1);
            end else if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + SHIFT_W'(1);
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                r_a <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_dest_found = r_out_found;
    assign o_dest_index = r_out_index;
endmodule

### rtl/core/weighted_round_robin_scheduler.sv
// Top level of the weighted round-robin scheduler.
// Depends on wrrs_pkg, wrrs_ctrl, wrrs_dp (which holds wrrs_ram).
//
//  channel   handshake                 payload
//  input     start & !busy             i_kind, i_entry_index, i_entry_weight,
//                                      i_entry_available
//  result    o_valid (one cycle)       o_dest_found, o_dest_index
//  config    i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
// Write and unknown items are taken in S_IDLE without leaving it. A packet passes
// through S_PKT, which registers its result; a pointer walk then alternates
// S_WSTEP and S_WCHK per table entry visited. A commit scans the used entries
// in S_CRD and S_CUSE, with binary gcd iterations in S_GCD for each positive
// weight after the first, then ends in S_CFIN. Reset is synchronous, active
// low; the table is not cleared. Results cannot be stalled.
module weighted_round_robin_scheduler import wrrs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_kind,
    input  logic [IDX_W-1:0]       i_entry_index,
    input  logic [WEIGHT_BITS-1:0] i_entry_weight,
    input  logic                   i_entry_available,
    output logic                   o_valid,
    output logic                   o_dest_found,
    output logic [IDX_W-1:0]       o_dest_index,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);
    t_cmd cmd;
    t_sts sts;
    logic start_ok;

    assign start_ok    = start && !busy;
    assign o_cfg_ready = 1'b1;

    wrrs_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start_ok),
        .i_kind (i_kind),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    wrrs_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_kind           (i_kind),
        .i_entry_index    (i_entry_index),
        .i_entry_weight   (i_entry_weight),
        .i_entry_available(i_entry_available),
        .i_cfg_wr         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_dest_found     (o_dest_found),
        .o_dest_index     (o_dest_index)
    );
endmodule

### tb/tb_top.sv
// Self-checking testbench for the weighted round-robin scheduler.
// Depends on wrrs_pkg and weighted_round_robin_scheduler. A local predictor
// tracks the table and pointer and checks every packet decision.
module tb_top;
    import wrrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]             kind;
        logic [IDX_W-1:0]       idx;
        logic [WEIGHT_BITS-1:0] weight;
        logic                   avail;
    } t_item;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_dest;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [1:0]             i_kind;
    logic [IDX_W-1:0]       i_entry_index;
    logic [WEIGHT_BITS-1:0] i_entry_weight;
    logic                   i_entry_available;
    logic                   o_valid;
    logic                   o_dest_found;
    logic [IDX_W-1:0]       o_dest_index;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic                   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    weighted_round_robin_scheduler u_dut (.*);

    // scheduler model state
    int unsigned m_weight [MAX_DESTS];
    bit          m_avail  [MAX_DESTS];
    bit          m_at_head;
    int unsigned m_pos;
    int          m_cur_weight;
    int unsigned m_max_weight;
    int unsigned m_step;
    int unsigned m_skip;
    int unsigned m_dest_count;
    int unsigned m_skip_interval;

    t_item pending_items[$];
    t_dest expected_dests[$];
    int    errors;
    int    accepted;
    int    cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned used_entries();
        return (m_dest_count > MAX_DESTS) ? MAX_DESTS : m_dest_count;
    endfunction

    function automatic int unsigned gcd(int unsigned a, int unsigned b);
        int unsigned r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // recompute max weight and gcd step, rewind the pointer
    function automatic void commit_weights();
        int unsigned n;
        int unsigned mx;
        int unsigned g;
        n  = used_entries();
        mx = 0;
        g  = 0;
        for (int i = 0; i < n; i++) begin
            if (m_weight[i] > mx) mx = m_weight[i];
            if (m_weight[i] > 0) g = (g > 0) ? gcd(m_weight[i], g) : m_weight[i];
        end
        m_max_weight = mx;
        m_step       = (g != 0) ? g : 1;
        m_skip       = 0;
        m_at_head    = 1'b1;
        m_pos        = 0;
        if (m_cur_weight > int'(m_max_weight)) m_cur_weight = 0;
    endfunction

    // advance the pointer to the next eligible destination, or park it at the head
    function automatic void advance_pointer();
        int unsigned n;
        bit          head0;
        int unsigned pos0;
        n = used_entries();
        if (!m_at_head && m_pos >= n) m_at_head = 1'b1;
        head0 = m_at_head;
        pos0  = m_pos;
        forever begin
            if (m_at_head) begin
                if (n == 0) return;
                m_at_head = 1'b0;
                m_pos = 0;
                m_cur_weight -= int'(m_step);
                if (m_cur_weight <= 0) begin
                    m_cur_weight = int'(m_max_weight);
                    if (m_cur_weight == 0) begin
                        m_at_head = 1'b1;
                        return;
                    end
                end
            end else begin
                m_pos++;
                if (m_pos >= n) begin
                    m_at_head = 1'b1;
                    m_pos = 0;
                end
            end
            if (!m_at_head && m_avail[m_pos] && int'(m_weight[m_pos]) >= m_cur_weight)
                return;
            if (m_at_head == head0 && (m_at_head || m_pos == pos0) &&
                m_cur_weight == int'(m_step)) begin
                m_at_head = 1'b1;
                m_pos = 0;
                return;
            end
        end
    endfunction

    // apply one accepted transaction, queue the expected decision
    function automatic void schedule_item(t_item it);
        t_dest d;
        case (it.kind)
            KIND_WRITE: begin
                m_weight[it.idx] = it.weight;
                m_avail[it.idx]  = it.avail;
            end
            KIND_COMMIT: commit_weights();
            KIND_PACKET: begin
                d.found = !m_at_head && m_pos < used_entries();
                d.idx   = d.found ? m_pos[IDX_W-1:0] : '0;
                expected_dests.push_back(d);
                if (m_skip < m_skip_interval) begin
                    m_skip = (m_skip + 1) & 8'hFF;
                end else begin
                    m_skip = 0;
                    advance_pointer();
                end
            end
            default: ;
        endcase
    endfunction

    // large weights are always available so walks stay short
    function automatic t_item make_write(int idx, int w, bit av);
        t_item it;
        it.kind   = KIND_WRITE;
        it.idx    = idx[IDX_W-1:0];
        it.weight = w[WEIGHT_BITS-1:0];
        it.avail  = (w > 31) ? 1'b1 : av;
        return it;
    endfunction

    function automatic t_item make_op(logic [1:0] kind);
        t_item it;
        it.kind   = kind;
        it.idx    = IDX_W'($urandom);
        it.weight = WEIGHT_BITS'($urandom);
        it.avail  = 1'($urandom);
        return it;
    endfunction

    function automatic t_item random_item();
        int r;
        int w;
        r = $urandom_range(99);
        if (r < 30) begin
            case ($urandom_range(3))
                0: w = $urandom_range(31);
                1: w = $urandom_range(15) * 4096;
                2: w = $urandom_range(65535);
                default: w = $urandom_range(7) * 2;
            endcase
            return make_write($urandom_range(63), w, 1'($urandom));
        end
        if (r < 40) return make_op(KIND_COMMIT);
        if (r < 95) return make_op(KIND_PACKET);
        return make_op(2'd3);
    endfunction

    // driver: hold start until accepted, random gaps outside the quiet window
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) begin
                schedule_item({i_kind, i_entry_index, i_entry_weight, i_entry_available});
                accepted++;
            end
            if (pending_items.size() > 0 &&
                ((accepted >= 600 && accepted < 900) || $urandom_range(99) >= 18)) begin
                {i_kind, i_entry_index, i_entry_weight, i_entry_available}
                    <= pending_items.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_dests.size() == 0) begin
                $display("%0t: unexpected result found=%0d index=%0d",
                         $realtime, o_dest_found, o_dest_index);
                errors++;
            end else begin
                t_dest e;
                e = expected_dests.pop_front();
                if (o_dest_found !== e.found || o_dest_index !== e.idx) begin
                    $display("%0t: expected found=%0d index=%0d, got found=%0d index=%0d",
                             $realtime, e.found, e.idx, o_dest_found, o_dest_index);
                    errors++;
                end
            end
        end
    end

    // watchdog: long weight descents make single walks very long
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 200000000) begin
            $display("weighted_round_robin_scheduler regression: fail");
            $finish;
        end
    end

    // sample between edges so driver and DUT updates have settled
    task automatic wait_drained(int extra);
        do @(negedge i_clk);
        while (pending_items.size() > 0 || start || busy || expected_dests.size() > 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic index, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        if (index == CFG_DEST_COUNT) m_dest_count = data & 8'h7F;
        else m_skip_interval = data;
        i_cfg_valid <= 1'b0;
    endtask

    int dc;
    int si;

    initial begin
        errors = 0;
        accepted = 0;
        cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_kind = KIND_WRITE;
        i_entry_index = '0;
        i_entry_weight = '0;
        i_entry_available = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DEST_COUNT;
        i_cfg_data = '0;
        m_at_head = 1'b1;
        m_pos = 0;
        m_cur_weight = 0;
        m_max_weight = 0;
        m_step = 1;
        m_skip = 0;
        m_dest_count = 0;
        m_skip_interval = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // packets on the empty default table report none
        repeat (3) pending_items.push_back(make_op(KIND_PACKET));
        pending_items.push_back(make_op(KIND_COMMIT));
        pending_items.push_back(make_op(KIND_PACKET));
        wait_drained(8);

        // fill every entry so no unwritten entry is ever read
        for (int i = 0; i < MAX_DESTS; i++)
            pending_items.push_back(make_write(i, $urandom_range(31), 1'($urandom)));
        wait_drained(8);
        cfg_write(CFG_DEST_COUNT, 8'd64);
        cfg_write(CFG_SKIP_INTERVAL, 8'd0);

        // directed: extreme weights, unknown kind, then zero weights on entries 1 and 60-63
        pending_items.push_back(make_write(63, 65535, 1'b1));
        pending_items.push_back(make_write(0, 0, 1'b0));
        pending_items.push_back(make_write(1, 21845, 1'b1));
        pending_items.push_back(make_op(KIND_COMMIT));
        repeat (4) pending_items.push_back(make_op(KIND_PACKET));
        pending_items.push_back(make_op(2'd3));
        pending_items.push_back(make_op(KIND_PACKET));
        for (int i = 0; i < 4; i++) pending_items.push_back(make_write(60 + i, 0, 1'b1));
        pending_items.push_back(make_write(1, 0, 1'b1));
        wait_drained(8);
        // shrink the table without a commit: pointer beyond the count
        cfg_write(CFG_DEST_COUNT, 8'd2);
        repeat (3) pending_items.push_back(make_op(KIND_PACKET));
        wait_drained(8);
        // the used count saturates at the maximum
        cfg_write(CFG_DEST_COUNT, 8'hFF);
        cfg_write(CFG_SKIP_INTERVAL, 8'd255);
        pending_items.push_back(make_op(KIND_COMMIT));
        repeat (4) pending_items.push_back(make_op(KIND_PACKET));
        wait_drained(8);
        // skip count above a shrunk interval walks at once
        cfg_write(CFG_SKIP_INTERVAL, 8'd1);
        repeat (3) pending_items.push_back(make_op(KIND_PACKET));
        wait_drained(8);

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(4))
                0: dc = 0;
                1: dc = 1;
                2: dc = 64;
                3: dc = 8'h80 | $urandom_range(127);
                default: dc = $urandom_range(2, 70);
            endcase
            case ($urandom_range(3))
                0: si = 0;
                1: si = 255;
                default: si = $urandom_range(3);
            endcase
            if (ph == 0) dc = 64;
            if (ph == 1) si = 0;
            cfg_write(CFG_DEST_COUNT, dc[7:0]);
            cfg_write(CFG_SKIP_INTERVAL, si[7:0]);
            if ($urandom_range(1)) pending_items.push_back(make_op(KIND_COMMIT));
            repeat (180) pending_items.push_back(random_item());
            wait_drained(8);
        end

        wait_drained(50);
        if (errors == 0)
            $display("weighted_round_robin_scheduler regression: pass");
        else
            $display("weighted_round_robin_scheduler regression: fail");
        $finish;
    end
endmodule
